[rtl/core/dfdl_pkg.sv]
// Shared constants and register indexes for the delimited frame decimal list parser.
package dfdl_pkg;

    // Byte codes used by the field parser
    localparam logic [7:0] COMMA_BYTE = 8'd44;
    localparam logic [7:0] DIGIT_ZERO = 8'd48;

    // Marker register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BEGIN_FIRST  = 3'd0,
        REG_BEGIN_SECOND = 3'd1,
        REG_END_FIRST    = 3'd2,
        REG_END_SECOND   = 3'd3
    } cfg_reg_t;

    // Marker reset values
    localparam logic [7:0] BEGIN_FIRST_RST  = 8'd170;
    localparam logic [7:0] BEGIN_SECOND_RST = 8'd85;
    localparam logic [7:0] END_FIRST_RST    = 8'd13;
    localparam logic [7:0] END_SECOND_RST   = 8'd10;

    // Comma count ceiling
    localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage

[rtl/core/dfdl_acc.sv]
// Decimal accumulator step (value*10 + byte - '0') and 32-bit output formatting.
module dfdl_acc #(
    parameter int VALUE_BITS = 32
) (
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [7:0]            digit_byte,
    output logic [VALUE_BITS-1:0] acc_next,
    output logic signed [31:0]    value_out
);

    logic [VALUE_BITS-1:0] times8;
    logic [VALUE_BITS-1:0] times2;

    // value*10 as shifted sum, wrapping at VALUE_BITS
    assign times8   = {acc[VALUE_BITS-4:0], 3'b000};
    assign times2   = {acc[VALUE_BITS-2:0], 1'b0};
    assign acc_next = times8 + times2 + VALUE_BITS'(digit_byte)
                      - VALUE_BITS'(dfdl_pkg::DIGIT_ZERO);

    // Sign-extend narrow values, keep the low word of wide ones
    generate
        if (VALUE_BITS >= 32) begin : g_wide
            assign value_out = acc[31:0];
        end else begin : g_narrow
            assign value_out = {{(32-VALUE_BITS){acc[VALUE_BITS-1]}}, acc};
        end
    endgenerate

endmodule

[rtl/core/delimited_frame_decimal_list_parser.sv]
// Top level of the delimited frame decimal list parser.
//
// Usage: received bytes enter on the s_ channel (s_valid/s_ready, s_rx_byte).
// A frame opens with the begin marker pair and closes with the end marker
// pair; the four marker bytes are set through the write port (cfg_we,
// cfg_index, cfg_wdata); the user must change them only while the block is
// idle, which the block does not enforce. Each comma inside a frame gives
// one field request on the m_ channel with frame_done low; the end pair
// gives a summary request with frame_done high. Most bytes give no request.
// A request appears on the m_ side in the cycle after the byte that causes
// it is accepted. Throughput: one byte per cycle unless a request waits,
// set by the single output register; the parse step is a shift-and-add of
// VALUE_BITS bits. While a request waits with m_ready low, s_ready is low,
// whether or not the next byte would give a request; it rises in the cycle
// the request is taken. Reset (aresetn, synchronous, active low) restores
// the default markers, leaves the frame, and clears all counts and m_valid.
module delimited_frame_decimal_list_parser #(
    parameter int MAX_FRAME  = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration write port
    input  logic                                    cfg_we,
    input  logic [dfdl_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [7:0]                              cfg_wdata,
    // Byte input
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_rx_byte,
    // Result output
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_frame_done,
    output logic [7:0]                              m_field_index,
    output logic signed [31:0]                      m_field_value,
    output logic                                    m_too_long,
    output logic                                    m_count_saturated
);

    localparam int FB_W = $clog2(MAX_FRAME + 2);
    localparam logic [FB_W-1:0] FB_MAX = FB_W'(MAX_FRAME);

    // Marker registers
    logic [7:0] begin_first_reg, begin_second_reg, end_first_reg, end_second_reg;

    // Parser state
    logic                  in_frame_reg, in_frame_next;
    logic [7:0]            prev_byte_reg, prev_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [7:0]            comma_count_reg, comma_count_next;
    logic [FB_W-1:0]       frame_bytes_reg, frame_bytes_next;
    logic                  sat_reg, sat_next;

    // Output register
    logic               m_valid_reg;
    logic               out_done_reg, out_done_next;
    logic [7:0]         out_index_reg, out_index_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_long_reg, out_long_next;
    logic               out_sat_reg, out_sat_next;
    logic               emit;

    logic                  accept;
    logic [VALUE_BITS-1:0] acc_step;
    logic signed [31:0]    acc_value;
    logic [FB_W-1:0]       fb_inc;
    logic                  begin_hit;
    logic                  end_hit;
    logic                  count_full;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    dfdl_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_acc (
        .acc        (acc_reg),
        .digit_byte (prev_byte_reg),
        .acc_next   (acc_step),
        .value_out  (acc_value)
    );

    // Marker writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_first_reg  <= dfdl_pkg::BEGIN_FIRST_RST;
            begin_second_reg <= dfdl_pkg::BEGIN_SECOND_RST;
            end_first_reg    <= dfdl_pkg::END_FIRST_RST;
            end_second_reg   <= dfdl_pkg::END_SECOND_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                dfdl_pkg::REG_BEGIN_FIRST:  begin_first_reg  <= cfg_wdata;
                dfdl_pkg::REG_BEGIN_SECOND: begin_second_reg <= cfg_wdata;
                dfdl_pkg::REG_END_FIRST:    end_first_reg    <= cfg_wdata;
                dfdl_pkg::REG_END_SECOND:   end_second_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign begin_hit  = (prev_byte_reg == begin_first_reg) && (s_rx_byte == begin_second_reg);
    assign end_hit    = held_valid_reg && (prev_byte_reg == end_first_reg)
                        && (s_rx_byte == end_second_reg);
    assign fb_inc     = (frame_bytes_reg <= FB_MAX) ? frame_bytes_reg + 1'b1 : frame_bytes_reg;
    assign count_full = (comma_count_reg == dfdl_pkg::COUNT_MAX);

    // Per-byte parse step
    always_comb begin
        in_frame_next    = in_frame_reg;
        prev_byte_next   = prev_byte_reg;
        held_valid_next  = held_valid_reg;
        acc_next         = acc_reg;
        comma_count_next = comma_count_reg;
        frame_bytes_next = frame_bytes_reg;
        sat_next         = sat_reg;
        emit             = 1'b0;
        out_done_next    = 1'b0;
        out_index_next   = comma_count_reg;
        out_value_next   = acc_value;
        out_long_next    = 1'b0;
        out_sat_next     = sat_reg;

        if (begin_hit) begin
            // Begin pair: (re)start the frame
            in_frame_next    = 1'b1;
            prev_byte_next   = '0;
            held_valid_next  = 1'b0;
            acc_next         = '0;
            comma_count_next = '0;
            frame_bytes_next = '0;
            sat_next         = 1'b0;
        end else if (!in_frame_reg) begin
            prev_byte_next = s_rx_byte;
        end else if (end_hit) begin
            // End pair: summary request
            frame_bytes_next = fb_inc;
            emit             = 1'b1;
            out_done_next    = 1'b1;
            out_long_next    = (fb_inc > FB_MAX);
            in_frame_next    = 1'b0;
            held_valid_next  = 1'b0;
            prev_byte_next   = '0;
        end else begin
            frame_bytes_next = fb_inc;
            if (held_valid_reg) begin
                if (prev_byte_reg == dfdl_pkg::COMMA_BYTE) begin
                    // Comma: field request, count saturates at its ceiling
                    if (count_full) begin
                        sat_next = 1'b1;
                    end else begin
                        comma_count_next = comma_count_reg + 8'd1;
                    end
                    emit         = 1'b1;
                    out_sat_next = sat_reg || count_full;
                    acc_next     = '0;
                end else begin
                    acc_next = acc_step;
                end
            end
            prev_byte_next  = s_rx_byte;
            held_valid_next = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            prev_byte_reg   <= '0;
            held_valid_reg  <= 1'b0;
            acc_reg         <= '0;
            comma_count_reg <= '0;
            frame_bytes_reg <= '0;
            sat_reg         <= 1'b0;
        end else if (accept) begin
            in_frame_reg    <= in_frame_next;
            prev_byte_reg   <= prev_byte_next;
            held_valid_reg  <= held_valid_next;
            acc_reg         <= acc_next;
            comma_count_reg <= comma_count_next;
            frame_bytes_reg <= frame_bytes_next;
            sat_reg         <= sat_next;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_done_reg  <= out_done_next;
            out_index_reg <= out_index_next;
            out_value_reg <= out_value_next;
            out_long_reg  <= out_long_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_frame_done      = out_done_reg;
    assign m_field_index     = out_index_reg;
    assign m_field_value     = out_value_reg;
    assign m_too_long        = out_long_reg;
    assign m_count_saturated = out_sat_reg;

endmodule

[dv/tb_delimited_frame_decimal_list_parser.sv]
// Self-checking testbench for the delimited frame decimal list parser.
`timescale 1ns / 1ps

module tb_delimited_frame_decimal_list_parser;

    localparam int FRAME_LIMIT   = 256;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_QUOTA   = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_START    = 40;
    localparam int LONG_HOLD     = 400;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam logic [31:0] RADIX = 32'd10;
    // index outside the marker map, writes to it must be dropped
    localparam logic [dfdl_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd5;

    typedef struct packed {
        logic        done;
        logic [7:0]  index;
        logic [31:0] value;
        logic        too_long;
        logic        saturated;
    } parse_result_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [dfdl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                       cfg_wdata = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    logic [7:0]                       s_rx_byte = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    logic                             m_frame_done;
    logic [7:0]                       m_field_index;
    logic signed [31:0]               m_field_value;
    logic                             m_too_long;
    logic                             m_count_saturated;

    delimited_frame_decimal_list_parser #(
        .MAX_FRAME  (FRAME_LIMIT),
        .VALUE_BITS (32)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_done      (m_frame_done),
        .m_field_index     (m_field_index),
        .m_field_value     (m_field_value),
        .m_too_long        (m_too_long),
        .m_count_saturated (m_count_saturated)
    );

    // Byte stream waiting to be sent and results still owed by the block
    logic [7:0]    pending_bytes [$];
    parse_result_t owed_results [$];

    // Marker copy and parser state of the prediction
    logic [7:0]  mk_begin1 = dfdl_pkg::BEGIN_FIRST_RST;
    logic [7:0]  mk_begin2 = dfdl_pkg::BEGIN_SECOND_RST;
    logic [7:0]  mk_end1   = dfdl_pkg::END_FIRST_RST;
    logic [7:0]  mk_end2   = dfdl_pkg::END_SECOND_RST;
    logic        pr_in_frame = 1'b0;
    logic [7:0]  pr_prev     = '0;
    logic        pr_held     = 1'b0;
    logic [31:0] pr_acc      = '0;
    logic [7:0]  pr_commas   = '0;
    int          pr_bytes    = 0;
    logic        pr_sat      = 1'b0;

    int src_idle_pct = 11;
    int snk_idle_pct = 52;
    int bytes_sent   = 0;
    int items_made   = 0;
    int fields_seen  = 0;
    int frames_seen  = 0;
    int mismatches   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    initial forever #6 aclk = ~aclk;

    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d requests still owed", owed_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Advance the parser copy by one accepted byte
    task automatic parse_byte(input logic [7:0] b);
        parse_result_t r;
        if (pr_prev == mk_begin1 && b == mk_begin2) begin
            // begin pair opens or restarts a frame
            pr_in_frame = 1'b1;
            pr_prev     = '0;
            pr_held     = 1'b0;
            pr_acc      = '0;
            pr_commas   = '0;
            pr_bytes    = 0;
            pr_sat      = 1'b0;
        end else if (!pr_in_frame) begin
            pr_prev = b;
        end else begin
            if (pr_bytes <= FRAME_LIMIT)
                pr_bytes++;
            if (pr_held && pr_prev == mk_end1 && b == mk_end2) begin
                r.done      = 1'b1;
                r.index     = pr_commas;
                r.value     = pr_acc;
                r.too_long  = (pr_bytes > FRAME_LIMIT);
                r.saturated = pr_sat;
                owed_results.push_back(r);
                pr_in_frame = 1'b0;
                pr_held     = 1'b0;
                pr_prev     = '0;
            end else begin
                if (pr_held) begin
                    if (pr_prev == dfdl_pkg::COMMA_BYTE) begin
                        r.done     = 1'b0;
                        r.index    = pr_commas;
                        r.value    = pr_acc;
                        r.too_long = 1'b0;
                        if (pr_commas == dfdl_pkg::COUNT_MAX)
                            pr_sat = 1'b1;
                        else
                            pr_commas++;
                        r.saturated = pr_sat;
                        owed_results.push_back(r);
                        pr_acc = '0;
                    end else begin
                        pr_acc = pr_acc * RADIX + {24'd0, pr_prev}
                                 - {24'd0, dfdl_pkg::DIGIT_ZERO};
                    end
                end
                pr_prev = b;
                pr_held = 1'b1;
            end
        end
    endtask

    // Byte sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Compare one taken request with the oldest owed result
    task automatic check_result();
        parse_result_t want;
        if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected request: done=%0d idx=%0d val=%0d long=%0d sat=%0d",
                         m_frame_done, m_field_index, m_field_value, m_too_long,
                         m_count_saturated);
        end else begin
            want = owed_results.pop_front();
            if (want.done) frames_seen++; else fields_seen++;
            if (m_frame_done !== want.done || m_field_index !== want.index ||
                m_field_value !== want.value || m_too_long !== want.too_long ||
                m_count_saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp done=%0d idx=%0d val=%0d long=%0d sat=%0d",
                             want.done, want.index, $signed(want.value), want.too_long,
                             want.saturated);
                    $display("          got done=%0d idx=%0d val=%0d long=%0d sat=%0d",
                             m_frame_done, m_field_index, m_field_value,
                             m_too_long, m_count_saturated);
                end
            end
        end
    endtask

    // Long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && bytes_sent >= HOLD_START) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        items_made++;
    endtask

    // Mostly digits and commas, some arbitrary bytes
    function automatic logic [7:0] payload_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return dfdl_pkg::DIGIT_ZERO + 8'($urandom_range(9));
        else if (pick < 80)
            return dfdl_pkg::COMMA_BYTE;
        return 8'($urandom_range(255));
    endfunction

    // One frame under the current markers, sometimes with a broken end
    task automatic add_frame();
        int i, noise, len, tail;
        noise = $urandom_range(2);
        for (i = 0; i < noise; i++)
            push_byte(8'($urandom_range(255)));
        len = ($urandom_range(99) < 1) ? $urandom_range(250, 300) : $urandom_range(16);
        push_byte(mk_begin1);
        push_byte(mk_begin2);
        for (i = 0; i < len; i++)
            push_byte(payload_byte());
        tail = $urandom_range(99);
        if (tail >= 8)
            push_byte(mk_end1);
        if (tail >= 14)
            push_byte(mk_end2);
    endtask

    task automatic write_marker(input logic [dfdl_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            dfdl_pkg::REG_BEGIN_FIRST:  mk_begin1 = val;
            dfdl_pkg::REG_BEGIN_SECOND: mk_begin2 = val;
            dfdl_pkg::REG_END_FIRST:    mk_end1   = val;
            dfdl_pkg::REG_END_SECOND:   mk_end2   = val;
            default: ;
        endcase
    endtask

    task automatic set_markers(input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] e1, input logic [7:0] e2);
        write_marker(dfdl_pkg::REG_BEGIN_FIRST, b1);
        write_marker(dfdl_pkg::REG_BEGIN_SECOND, b2);
        write_marker(dfdl_pkg::REG_END_FIRST, e1);
        write_marker(dfdl_pkg::REG_END_SECOND, e2);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Sender pauses here until every owed result is back
    task automatic wait_for_drain();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Phases of stimulus, one marker setting each
    initial begin
        int ph, k, quota_end;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_for_drain();
                src_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 52 : 0;
                snk_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 11 : 0;
                case (ph)
                    1: begin
                        set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
                        write_marker(REG_UNMAPPED, 8'h5A);
                        @(posedge aclk);
                        cfg_we <= 1'b0;
                    end
                    2: set_markers(8'hFF, 8'h00, 8'h00, 8'hFF);
                    default: set_markers(8'($urandom_range(255)), 8'($urandom_range(255)),
                                         8'($urandom_range(255)), 8'($urandom_range(255)));
                endcase
            end
            if (ph == 0) begin
                // extremes and end pair outside a frame give nothing
                push_byte(8'h00);
                push_byte(8'hFF);
                push_byte(mk_end1);
                push_byte(mk_end2);
                // digits, comma, non-digit bytes in the formula
                push_byte(mk_begin1);
                push_byte(mk_begin2);
                push_byte(dfdl_pkg::DIGIT_ZERO + 8'd1);
                push_byte(dfdl_pkg::DIGIT_ZERO + 8'd2);
                push_byte(dfdl_pkg::COMMA_BYTE);
                push_byte(8'hFF);
                push_byte(8'h00);
                push_byte(dfdl_pkg::COMMA_BYTE);
                // begin pair inside a frame restarts it
                push_byte(mk_begin1);
                push_byte(mk_begin2);
                push_byte(dfdl_pkg::DIGIT_ZERO + 8'd9);
                push_byte(dfdl_pkg::COMMA_BYTE);
                push_byte(mk_end1);
                push_byte(mk_end2);
                // empty frame: end pair right after the begin pair
                push_byte(mk_begin1);
                push_byte(mk_begin2);
                push_byte(mk_end1);
                push_byte(mk_end2);
                // comma count runs into its ceiling, frame runs over length
                push_byte(mk_begin1);
                push_byte(mk_begin2);
                for (k = 0; k < 260; k++) begin
                    push_byte(dfdl_pkg::DIGIT_ZERO + 8'(k % 10));
                    push_byte(dfdl_pkg::COMMA_BYTE);
                end
                push_byte(mk_end1);
                push_byte(mk_end2);
            end else if (ph == 1) begin
                // zero first begin byte: each lone second byte restarts again
                push_byte(8'h00);
                push_byte(8'hFF);
                push_byte(8'hFF);
                push_byte(dfdl_pkg::DIGIT_ZERO + 8'd5);
                push_byte(dfdl_pkg::COMMA_BYTE);
                push_byte(dfdl_pkg::DIGIT_ZERO + 8'd3);
                push_byte(8'hFF);
                push_byte(8'h00);
            end
            quota_end = items_made + PHASE_QUOTA;
            while (items_made < quota_end)
                add_frame();
        end
        wait_for_drain();
        repeat (20) @(posedge aclk);
        $display("sent %0d bytes under %0d marker settings, with stalls on both sides",
                 bytes_sent, NUM_PHASES);
        $display("checked %0d field and %0d frame requests", fields_seen, frames_seen);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d requests owed", mismatches, owed_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dfdl_pkg.sv
rtl/core/dfdl_acc.sv
rtl/core/delimited_frame_decimal_list_parser.sv
dv/tb_delimited_frame_decimal_list_parser.sv
